// ===== sv/spq_pkg.sv =====
package spq_pkg;

  // Queue geometry.
  localparam int CAPACITY    = 8;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CMD_W       = 2;
  localparam int ERR_W       = 2;
  localparam int COUNT_OUT_W = 4;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STATUS = 2'd3;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Result of one command, handed from the sequencer to the output stage.
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] removed_value;
    logic                     removed_valid;
    logic [ERR_W-1:0]         error_code;
    cnt_t                     count;
  } res_t;

  // Circular buffer pointer step forward.
  function automatic idx_t ptr_inc(input idx_t p);
    idx_t r;
    if (p == idx_t'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = p + idx_t'(1);
    end
    return r;
  endfunction

  // Circular buffer pointer step backward.
  function automatic idx_t ptr_dec(input idx_t p);
    idx_t r;
    if (p == '0) begin
      r = idx_t'(CAPACITY - 1);
    end else begin
      r = p - idx_t'(1);
    end
    return r;
  endfunction

endpackage

// ===== sv/spq_ram.sv =====
module spq_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/spq_ctrl.sv =====
module spq_ctrl import spq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [DATA_W-1:0] value,
  output logic                     busy,
  output logic                     mem_we,
  output idx_t                     mem_waddr,
  output logic [DATA_W-1:0]        mem_wdata,
  output idx_t                     mem_raddr,
  input  logic [DATA_W-1:0]        mem_rdata,
  output res_t                     res
);

  localparam int STATE_W = 2;
  localparam logic [STATE_W-1:0] S_IDLE  = 2'd0;
  localparam logic [STATE_W-1:0] S_SCAN  = 2'd1;
  localparam logic [STATE_W-1:0] S_PLACE = 2'd2;
  localparam logic [STATE_W-1:0] S_REM   = 2'd3;

  logic [STATE_W-1:0]       state, state_next;
  idx_t                     head, head_next;
  idx_t                     tail, tail_next;
  cnt_t                     count, count_next;
  idx_t                     wr_ptr, wr_ptr_next;
  idx_t                     rd_ptr, rd_ptr_next;
  idx_t                     pos, pos_next;
  logic signed [DATA_W-1:0] ins_val, ins_val_next;
  logic                     finish_insert;

  assign busy = (state != S_IDLE);

  // Sequencer: inserts walk from the tail toward the head, one entry a cycle,
  // moving each smaller entry one slot back until the new value's place is found.
  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    wr_ptr_next   = wr_ptr;
    rd_ptr_next   = rd_ptr;
    pos_next      = pos;
    ins_val_next  = ins_val;
    finish_insert = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = wr_ptr;
    mem_wdata     = ins_val;
    mem_raddr     = rd_ptr;
    res           = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (command)
            CMD_INSERT: begin
              ins_val_next = value;
              if (count == cnt_t'(CAPACITY)) begin
                res.valid      = 1'b1;
                res.error_code = ERR_FULL;
              end else if (count == '0) begin
                mem_we        = 1'b1;
                mem_waddr     = tail;
                mem_wdata     = value;
                finish_insert = 1'b1;
              end else begin
                wr_ptr_next = tail;
                rd_ptr_next = ptr_dec(tail);
                mem_raddr   = ptr_dec(tail);
                pos_next    = count[IDX_W-1:0];
                state_next  = S_SCAN;
              end
            end
            CMD_REMOVE: begin
              if (count == '0) begin
                res.valid      = 1'b1;
                res.error_code = ERR_EMPTY;
              end else begin
                mem_raddr  = head;
                state_next = S_REM;
              end
            end
            CMD_CLEAR: begin
              head_next  = '0;
              tail_next  = '0;
              count_next = '0;
              res.valid  = 1'b1;
            end
            CMD_STATUS: begin
              res.valid = 1'b1;
            end
            default: begin
              res.valid = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (ins_val > $signed(mem_rdata)) begin
          // Entry is smaller: move it one slot back and keep walking.
          mem_we      = 1'b1;
          mem_wdata   = mem_rdata;
          wr_ptr_next = rd_ptr;
          pos_next    = pos - idx_t'(1);
          if (pos == idx_t'(1)) begin
            state_next = S_PLACE;
          end else begin
            rd_ptr_next = ptr_dec(rd_ptr);
            mem_raddr   = ptr_dec(rd_ptr);
          end
        end else begin
          mem_we        = 1'b1;
          finish_insert = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_PLACE: begin
        mem_we        = 1'b1;
        finish_insert = 1'b1;
        state_next    = S_IDLE;
      end
      S_REM: begin
        res.valid         = 1'b1;
        res.removed_value = $signed(mem_rdata);
        res.removed_valid = 1'b1;
        head_next         = ptr_inc(head);
        count_next        = count - cnt_t'(1);
        state_next        = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A completed insert grows the queue by one at the tail.
    if (finish_insert) begin
      tail_next  = ptr_inc(tail);
      count_next = count + cnt_t'(1);
      res.valid  = 1'b1;
    end
    res.count = count_next;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Walk pointers and the value being inserted.
  always_ff @(posedge clk) begin
    wr_ptr  <= wr_ptr_next;
    rd_ptr  <= rd_ptr_next;
    pos     <= pos_next;
    ins_val <= ins_val_next;
  end

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue of signed 32-bit values, largest first.
// Commands enter on start/command/value; a transfer happens at a rising edge
// with start high and busy low. Insert places the value behind every stored
// value greater than or equal to it, remove returns the largest, clear
// empties the queue, status changes nothing.
// Every command produces exactly one result, shown for one cycle with done
// high: removed_value/removed_valid, error_code, and is_empty, is_full and
// entry_count as they stand after the command. The receiver cannot stall;
// the result must be taken in that cycle.
// Clear, status, refused commands and an insert into an empty queue complete
// from the idle state; a remove reads the head and returns it from S_REM; an
// insert into a non-empty queue stays in S_SCAN while it moves stored entries
// (at most CAPACITY - 1), ending in S_PLACE if it moves all of them. The entries
// live in a circular buffer in one RAM with a registered read; an insert walks it
// one entry a cycle, so the next command can be accepted in the cycle done is high.
// Synchronous reset empties the queue and drops any command in progress; the
// RAM contents are not cleared.
module sorted_priority_queue import spq_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [CMD_W-1:0]              command,
  input  logic signed [DATA_W-1:0]      value,
  output logic                          done,
  output logic signed [DATA_W-1:0]      removed_value,
  output logic                          removed_valid,
  output logic [ERR_W-1:0]              error_code,
  output logic                          is_empty,
  output logic                          is_full,
  output logic [COUNT_OUT_W-1:0]        entry_count
);

  logic        mem_we;
  idx_t        mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  idx_t        mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  res_t        res;

  spq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start & ~busy),
    .command   (command),
    .value     (value),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res       (res)
  );

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
  end

  // Result payload and status flags derived from the new count.
  always_ff @(posedge clk) begin
    if (res.valid) begin
      removed_value <= res.removed_value;
      removed_valid <= res.removed_valid;
      error_code    <= res.error_code;
      is_empty      <= (res.count == '0);
      is_full       <= (res.count == cnt_t'(CAPACITY));
      entry_count   <= COUNT_OUT_W'(res.count);
    end
  end

  // A result never coincides with a command still in progress.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // A clear is reported with done in the following cycle and leaves the queue empty.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_CLEAR) |=> (done && is_empty && !is_full))
    else $error("clear did not empty the queue");

  // A refused remove only happens on an empty queue and returns nothing.
  assert property (@(posedge clk) disable iff (rst)
    (done && error_code == ERR_EMPTY) |-> (is_empty && !removed_valid))
    else $error("remove refused on a non-empty queue");

  // A removed entry always comes with a clean status.
  assert property (@(posedge clk) disable iff (rst)
    (done && removed_valid) |-> (error_code == ERR_NONE && !is_full))
    else $error("removal reported with an error or a full queue");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 1650;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 20;

  // One command waiting to be driven, with the idle cycles that go before it.
  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] val;
    int unsigned              gap;
    bit                       drain_first;
  } queue_cmd_t;

  // What the queue should report for one command.
  typedef struct {
    logic signed [DATA_W-1:0] removed_value;
    logic                     removed_valid;
    logic [ERR_W-1:0]         error_code;
    logic                     is_empty;
    logic                     is_full;
    logic [COUNT_OUT_W-1:0]   entry_count;
  } queue_reply_t;

  // Command mix of one burst of random traffic.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [CMD_W-1:0]         command = CMD_STATUS;
  logic signed [DATA_W-1:0] value = '0;
  logic                     busy;
  logic                     done;
  logic signed [DATA_W-1:0] removed_value;
  logic                     removed_valid;
  logic [ERR_W-1:0]         error_code;
  logic                     is_empty;
  logic                     is_full;
  logic [COUNT_OUT_W-1:0]   entry_count;

  queue_cmd_t   command_backlog[$];
  queue_reply_t queue_replies[$];

  // Shadow copy of the sorted contents, largest first.
  logic signed [DATA_W-1:0] sorted_vals[CAPACITY];
  int                       fill_level = 0;

  int fail_count = 0;
  int replies_checked = 0;
  int n_insert = 0, n_remove = 0, n_clear = 0, n_status = 0;
  int n_full_refused = 0, n_empty_refused = 0, n_reached_full = 0;

  sorted_priority_queue dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .value         (value),
    .done          (done),
    .removed_value (removed_value),
    .removed_valid (removed_valid),
    .error_code    (error_code),
    .is_empty      (is_empty),
    .is_full       (is_full),
    .entry_count   (entry_count)
  );

  always #6 clk = ~clk;

  // Apply one command to the shadow queue and return the report it should give.
  function automatic queue_reply_t apply_command(input logic [CMD_W-1:0] cmd,
                                                 input logic signed [DATA_W-1:0] val);
    queue_reply_t r;
    int           pos;
    r.removed_value = '0;
    r.removed_valid = 1'b0;
    r.error_code    = ERR_NONE;
    case (cmd)
      CMD_INSERT: begin
        n_insert++;
        if (fill_level >= CAPACITY) begin
          r.error_code = ERR_FULL;
          n_full_refused++;
        end else begin
          // The new value goes in front of the first strictly smaller one.
          pos = fill_level;
          for (int i = 0; i < fill_level; i++) begin
            if (val > sorted_vals[i]) begin
              pos = i;
              break;
            end
          end
          for (int i = fill_level; i > pos; i--) begin
            sorted_vals[i] = sorted_vals[i-1];
          end
          sorted_vals[pos] = val;
          fill_level++;
          if (fill_level == CAPACITY) n_reached_full++;
        end
      end
      CMD_REMOVE: begin
        n_remove++;
        if (fill_level == 0) begin
          r.error_code = ERR_EMPTY;
          n_empty_refused++;
        end else begin
          r.removed_value = sorted_vals[0];
          r.removed_valid = 1'b1;
          for (int i = 1; i < fill_level; i++) begin
            sorted_vals[i-1] = sorted_vals[i];
          end
          fill_level--;
        end
      end
      CMD_CLEAR: begin
        n_clear++;
        fill_level = 0;
      end
      default: begin
        n_status++;
      end
    endcase
    r.is_empty    = (fill_level == 0);
    r.is_full     = (fill_level == CAPACITY);
    r.entry_count = COUNT_OUT_W'(fill_level);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Mostly small values so that ties are common, some extremes, the rest anything.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      return DATA_W'(int'($urandom_range(0, 8)) - 4);
    end else if (roll < 50) begin
      case ($urandom_range(0, 4))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sh0000_0000;
        3: return 32'shFFFF_FFFF;
        default: return 32'sh0000_0001;
      endcase
    end else begin
      return $urandom;
    end
  endfunction

  // Idle gaps are mostly absent or short, with a few long ones.
  function automatic int unsigned pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    else if (roll < 95) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  function automatic void add_command(input logic [CMD_W-1:0] cmd,
                                      input logic signed [DATA_W-1:0] val,
                                      input int unsigned gap, input bit drain_first);
    queue_cmd_t c;
    c.cmd = cmd;
    c.val = val;
    c.gap = gap;
    c.drain_first = drain_first;
    command_backlog.push_back(c);
  endfunction

  // Driver: predict each transfer as it happens, then present the next command.
  bit           drv_took;
  int           drv_flight;
  int unsigned  idle_run = 0;
  int           in_flight = 0;
  queue_cmd_t   next_cmd;
  queue_reply_t next_reply;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_run <= 0;
      in_flight <= 0;
    end else begin
      drv_took = start && !busy;
      if (drv_took) begin
        next_reply = apply_command(command, value);
        queue_replies.push_back(next_reply);
      end
      drv_flight = in_flight + int'(drv_took) - int'(done);
      in_flight <= drv_flight;
      if (start && busy) begin
        // Hold the command until the queue takes it.
      end else if (command_backlog.size() == 0) begin
        start <= 1'b0;
      end else if (idle_run < command_backlog[0].gap) begin
        idle_run <= idle_run + 1;
        start <= 1'b0;
      end else if (command_backlog[0].drain_first && drv_flight != 0) begin
        start <= 1'b0;
      end else begin
        next_cmd = command_backlog.pop_front();
        start <= 1'b1;
        command <= next_cmd.cmd;
        value <= next_cmd.val;
        idle_run <= 0;
      end
    end
  end

  // Monitor: every done pulse is matched against the oldest predicted report.
  queue_reply_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (queue_replies.size() == 0) begin
        $display("%0t: result with none outstanding, expected nothing, actual value 0x%h",
                 $time, removed_value);
        fail_count++;
      end else begin
        want = queue_replies.pop_front();
        check_field("removed_value", want.removed_value, removed_value);
        check_field("removed_valid", DATA_W'(want.removed_valid), DATA_W'(removed_valid));
        check_field("error_code", DATA_W'(want.error_code), DATA_W'(error_code));
        check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(is_empty));
        check_field("is_full", DATA_W'(want.is_full), DATA_W'(is_full));
        check_field("entry_count", DATA_W'(want.entry_count), DATA_W'(entry_count));
        replies_checked++;
      end
    end
  end

  // Watchdog: stop if no transfer and no result happens for too long.
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus, reset and end of run.
  int   queued;
  int   burst_len;
  int   roll;
  bit   calm;
  mix_t mix;
  logic [CMD_W-1:0] cmd;

  initial begin
    for (int i = 0; i < CAPACITY; i++) sorted_vals[i] = '0;

    // Directed: refusals on empty, extremes, ties, overflow, full drain, clear.
    add_command(CMD_STATUS, 32'sh1234_5678, 0, 1'b0);
    add_command(CMD_REMOVE, 32'shFFFF_FFFF, 0, 1'b0);
    add_command(CMD_CLEAR, 32'sh7FFF_FFFF, 0, 1'b0);
    add_command(CMD_INSERT, 32'sh7FFF_FFFF, 0, 1'b0);
    add_command(CMD_INSERT, 32'sh8000_0000, 0, 1'b0);
    add_command(CMD_INSERT, 32'sh0000_0000, 1, 1'b0);
    add_command(CMD_INSERT, 32'shFFFF_FFFF, 0, 1'b0);
    add_command(CMD_INSERT, 32'sh0000_0005, 0, 1'b0);
    add_command(CMD_INSERT, 32'sh0000_0005, 0, 1'b0);
    add_command(CMD_INSERT, 32'sh0000_0001, 2, 1'b0);
    add_command(CMD_INSERT, 32'sh0000_0005, 0, 1'b0);
    add_command(CMD_INSERT, 32'sh0000_0064, 0, 1'b0);
    add_command(CMD_STATUS, 32'shDEAD_BEEF, 0, 1'b0);
    add_command(CMD_REMOVE, 32'sh5555_5555, 0, 1'b1);
    for (int i = 0; i < CAPACITY; i++) add_command(CMD_REMOVE, 32'shAAAA_AAAA, 0, 1'b0);
    add_command(CMD_INSERT, 32'sh0000_0003, 0, 1'b0);
    add_command(CMD_CLEAR, 32'sh0000_0000, 0, 1'b0);
    add_command(CMD_REMOVE, 32'sh0000_0000, 0, 1'b0);

    // Random: bursts that lean toward filling or draining the queue, or keep an even mix.
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      burst_len = $urandom_range(10, 60);
      mix = mix_t'($urandom_range(0, 2));
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst_len && queued < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        case (mix)
          MIX_FILL:  cmd = (roll < 70) ? CMD_INSERT : (roll < 90) ? CMD_REMOVE :
                           (roll < 97) ? CMD_STATUS : CMD_CLEAR;
          MIX_DRAIN: cmd = (roll < 25) ? CMD_INSERT : (roll < 90) ? CMD_REMOVE :
                           (roll < 97) ? CMD_STATUS : CMD_CLEAR;
          default:   cmd = (roll < 45) ? CMD_INSERT : (roll < 85) ? CMD_REMOVE :
                           (roll < 95) ? CMD_STATUS : CMD_CLEAR;
        endcase
        add_command(cmd, pick_value(), calm ? 0 : pick_gap(),
                    $urandom_range(0, 199) == 0);
        queued++;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for every command to be taken and every report to arrive.
    do begin
      @(negedge clk);
    end while (command_backlog.size() != 0 || start || queue_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Drove %0d commands: %0d inserts, %0d removes, %0d clears, %0d status; %0d reports checked.",
             n_insert + n_remove + n_clear + n_status, n_insert, n_remove, n_clear, n_status,
             replies_checked);
    $display("Queue filled up %0d times; %0d inserts refused as full, %0d removes refused as empty.",
             n_reached_full, n_full_refused, n_empty_refused);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
